/* hdl/admx_pkg.sv */
`default_nettype none

package admx_pkg;

    localparam int RING_DEPTH   = 4096;
    localparam int PTR_W        = $clog2(RING_DEPTH);
    localparam int FILL_W       = PTR_W + 1;
    localparam int MAX_CHANNELS = 8;
    localparam int IDX_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    localparam int SAMPLE_W   = 32;
    localparam int ACC_W      = 36;
    localparam int DIV_CNT_W  = $clog2(ACC_W);
    localparam int OUT_W      = 16;
    localparam int PROD_W     = 41;
    localparam int Q_FRAC     = 24;
    localparam int OUT_DATA_W = ((OUT_W + FILL_W + 7) / 8) * 8;

    localparam logic signed [SAMPLE_W-1:0] Q_ONE   = 32'sd16777216;
    localparam logic signed [SAMPLE_W-1:0] Q_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] Q_MIN   = 32'sh8000_0000;
    localparam logic signed [PROD_W-1:0]   Q_SCALE = 41'sd32767;

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_SILENT = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_BYTES  = 2'd1;
    localparam logic [1:0] CFG_FLOAT_FORMAT  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_ACC,
        ST_DIV,
        ST_PUSH,
        ST_RDMEM,
        ST_MUL,
        ST_SCALE,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

/* hdl/audio_downmix_ring_buffer.sv */
`default_nettype none

// Interleaved channel samples (float32 or 16/24/32-bit PCM) are converted to
// signed Q7.24, summed over one frame and divided by the channel count, and
// the mono result is written into a ring of RING_DEPTH entries that drops its
// oldest entry when full. A read command returns one entry, clamped to +/-1.0
// and scaled to 16 bits, with tuser low when the ring was empty. One item is
// in work at a time: a channel sample is converted and accumulated, and the
// sample that closes a frame then passes the 36-step bit-serial divider and
// the ring write; a silent frame goes straight to the ring write and an unused
// command is dropped; a read passes the ring memory read, multiplier, scaling
// and output register, or only the output register when the ring is empty.
// A finished result waits in the output register while the next item is
// already taken; a later read result holds in ST_OUT until the first is taken.
module audio_downmix_ring_buffer
    import admx_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [3:0]            i_cfg_data,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [SAMPLE_W-1:0]   s_axis_tdata,   // sample_bits
    input  wire logic [1:0]            s_axis_tuser,   // cmd

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // out_sample, fill_level, zero pad
    output logic                       m_axis_tuser    // out_valid
);

    // Configuration
    logic [3:0] r_channel_count;
    logic [2:0] r_sample_bytes;
    logic       r_float_format;

    // Ring memory and pointers
    logic [SAMPLE_W-1:0] r_mem [RING_DEPTH];
    logic [SAMPLE_W-1:0] r_rd_data;
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic                w_mem_we;
    logic [SAMPLE_W-1:0] w_push_data;

    // Frame and datapath state
    t_state                      r_state, n_state;
    logic [SAMPLE_W-1:0]         r_raw, n_raw;
    logic signed [SAMPLE_W-1:0]  r_q, n_q;
    logic signed [ACC_W-1:0]     r_acc, n_acc;
    logic [IDX_W-1:0]            r_ch_idx, n_ch_idx;
    logic [ACC_W-1:0]            r_div_num, n_div_num;
    logic [3:0]                  r_rem, n_rem;
    logic [DIV_CNT_W-1:0]        r_div_cnt, n_div_cnt;
    logic                        r_div_neg, n_div_neg;
    logic signed [PROD_W-1:0]    r_prod, n_prod;
    logic [OUT_W-1:0]            r_res_sample, n_res_sample;
    logic                        r_res_valid, n_res_valid;
    logic [FILL_W-1:0]           r_res_fill, n_res_fill;

    // Output register
    logic                  r_m_valid, n_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data, n_m_data;
    logic                  r_m_user, n_m_user;

    // Combinational helpers
    logic [3:0]                 w_n_eff;
    logic [2:0]                 w_nb_eff;
    logic signed [SAMPLE_W-1:0] w_conv;
    logic [7:0]                 w_ex;
    logic [23:0]                w_man;
    logic [7:0]                 w_rshift;
    logic [SAMPLE_W-1:0]        w_mag;
    logic signed [SAMPLE_W-1:0] w_pcm32;
    logic signed [ACC_W-1:0]    w_sum;
    logic                       w_frame_end;
    logic [4:0]                 w_rem_sh;
    logic                       w_qbit;
    logic signed [SAMPLE_W-1:0] w_rd_s;
    logic signed [25:0]         w_clamped;
    logic signed [PROD_W-1:0]   w_biased;
    logic signed [PROD_W-1:0]   w_scaled;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= 4'd2;
            r_sample_bytes  <= 3'd4;
            r_float_format  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data;
                CFG_SAMPLE_BYTES:  r_sample_bytes  <= i_cfg_data[2:0];
                CFG_FLOAT_FORMAT:  r_float_format  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_channel_count == 4'd0) begin
            w_n_eff = 4'd1;
        end else if (r_channel_count > 4'(MAX_CHANNELS)) begin
            w_n_eff = 4'(MAX_CHANNELS);
        end else begin
            w_n_eff = r_channel_count;
        end
        if (r_sample_bytes < 3'd2) begin
            w_nb_eff = 3'd2;
        end else if (r_sample_bytes > 3'd4) begin
            w_nb_eff = 3'd4;
        end else begin
            w_nb_eff = r_sample_bytes;
        end
    end

    // Sample conversion to Q7.24. Float values scale by 2^24 with truncation
    // toward zero; exponents past the Q7.24 range saturate, NaN gives zero.
    always_comb begin
        w_ex     = r_raw[30:23];
        w_man    = {1'b1, r_raw[22:0]};
        w_rshift = 8'd126 - w_ex;
        if (w_ex >= 8'd126) begin
            w_mag = SAMPLE_W'(w_man) << (w_ex - 8'd126);
        end else if (w_ex < 8'd102) begin
            w_mag = '0;
        end else begin
            w_mag = SAMPLE_W'(w_man >> w_rshift[4:0]);
        end
        w_pcm32 = $signed(r_raw + {25'd0, {7{r_raw[31]}}}) >>> 7;

        if (r_float_format) begin
            if (w_ex == 8'hFF) begin
                if (r_raw[22:0] != 23'd0) begin
                    w_conv = '0;
                end else begin
                    w_conv = r_raw[31] ? Q_MIN : Q_MAX;
                end
            end else if (w_ex == 8'd0) begin
                w_conv = '0;
            end else if (w_ex >= 8'd134) begin
                w_conv = r_raw[31] ? Q_MIN : Q_MAX;
            end else begin
                w_conv = r_raw[31] ? -$signed(w_mag) : $signed(w_mag);
            end
        end else begin
            case (w_nb_eff)
                3'd2:    w_conv = $signed({{7{r_raw[15]}}, r_raw[15:0], 9'd0});
                3'd3:    w_conv = $signed({{7{r_raw[23]}}, r_raw[23:0], 1'b0});
                default: w_conv = w_pcm32;
            endcase
        end
    end

    always_comb begin
        w_sum       = r_acc + ACC_W'(r_q);
        w_frame_end = ((4'(r_ch_idx) + 4'd1) >= w_n_eff);
        w_rem_sh    = {r_rem, r_div_num[ACC_W-1]};
        w_qbit      = (w_rem_sh >= {1'b0, w_n_eff});
        w_push_data = r_div_neg ? (~r_div_num[SAMPLE_W-1:0] + SAMPLE_W'(1))
                                : r_div_num[SAMPLE_W-1:0];

        w_rd_s = $signed(r_rd_data);
        if (w_rd_s > Q_ONE) begin
            w_clamped = 26'(Q_ONE);
        end else if (w_rd_s < -Q_ONE) begin
            w_clamped = 26'(-Q_ONE);
        end else begin
            w_clamped = 26'(w_rd_s);
        end
        // Bias negative products so the arithmetic shift truncates toward zero.
        w_biased = r_prod + (r_prod[PROD_W-1] ? PROD_W'((Q_ONE - 32'sd1)) : '0);
        w_scaled = w_biased >>> Q_FRAC;
    end

    always_comb begin
        n_state      = r_state;
        n_raw        = r_raw;
        n_q          = r_q;
        n_acc        = r_acc;
        n_ch_idx     = r_ch_idx;
        n_div_num    = r_div_num;
        n_rem        = r_rem;
        n_div_cnt    = r_div_cnt;
        n_div_neg    = r_div_neg;
        n_prod       = r_prod;
        n_res_sample = r_res_sample;
        n_res_valid  = r_res_valid;
        n_res_fill   = r_res_fill;
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_fill       = r_fill;
        w_mem_we     = 1'b0;
        n_m_valid    = r_m_valid & ~m_axis_tready;
        n_m_data     = r_m_data;
        n_m_user     = r_m_user;

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_raw = s_axis_tdata;
                    case (s_axis_tuser)
                        CMD_PUSH: n_state = ST_CONV;
                        CMD_SILENT: begin
                            // Drop the partial frame; write a zero straight to the ring.
                            n_acc     = '0;
                            n_ch_idx  = '0;
                            n_div_num = '0;
                            n_div_neg = 1'b0;
                            n_state   = ST_PUSH;
                        end
                        CMD_READ: begin
                            if (r_fill == '0) begin
                                n_res_sample = '0;
                                n_res_valid  = 1'b0;
                                n_res_fill   = '0;
                                n_state      = ST_OUT;
                            end else begin
                                n_state = ST_RDMEM;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CONV: begin
                n_q     = w_conv;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (w_frame_end) begin
                    n_div_neg = w_sum[ACC_W-1];
                    n_div_num = w_sum[ACC_W-1] ? ACC_W'(-w_sum) : ACC_W'(w_sum);
                    n_rem     = '0;
                    n_div_cnt = '0;
                    n_acc     = '0;
                    n_ch_idx  = '0;
                    n_state   = ST_DIV;
                end else begin
                    n_acc    = w_sum;
                    n_ch_idx = r_ch_idx + IDX_W'(1);
                    n_state  = ST_IDLE;
                end
            end
            ST_DIV: begin
                // Restoring division of the frame magnitude, one quotient bit a cycle.
                n_rem     = w_qbit ? 4'(w_rem_sh - {1'b0, w_n_eff}) : w_rem_sh[3:0];
                n_div_num = {r_div_num[ACC_W-2:0], w_qbit};
                n_div_cnt = r_div_cnt + DIV_CNT_W'(1);
                if (r_div_cnt == DIV_CNT_W'(ACC_W - 1)) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                w_mem_we = 1'b1;
                n_wr_ptr = r_wr_ptr + PTR_W'(1);
                if (r_fill < FILL_W'(RING_DEPTH)) begin
                    n_fill = r_fill + FILL_W'(1);
                end else begin
                    n_rd_ptr = r_rd_ptr + PTR_W'(1);
                end
                n_state = ST_IDLE;
            end
            ST_RDMEM: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_prod   = PROD_W'(w_clamped) * Q_SCALE;
                n_rd_ptr = r_rd_ptr + PTR_W'(1);
                n_fill   = r_fill - FILL_W'(1);
                n_state  = ST_SCALE;
            end
            ST_SCALE: begin
                n_res_sample = w_scaled[OUT_W-1:0];
                n_res_valid  = 1'b1;
                n_res_fill   = r_fill;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = OUT_DATA_W'({r_res_fill, r_res_sample});
                    n_m_user  = r_res_valid;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_acc     <= '0;
            r_ch_idx  <= '0;
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_fill    <= '0;
            r_div_cnt <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_acc     <= n_acc;
            r_ch_idx  <= n_ch_idx;
            r_wr_ptr  <= n_wr_ptr;
            r_rd_ptr  <= n_rd_ptr;
            r_fill    <= n_fill;
            r_div_cnt <= n_div_cnt;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raw        <= n_raw;
        r_q          <= n_q;
        r_div_num    <= n_div_num;
        r_rem        <= n_rem;
        r_div_neg    <= n_div_neg;
        r_prod       <= n_prod;
        r_res_sample <= n_res_sample;
        r_res_valid  <= n_res_valid;
        r_res_fill   <= n_res_fill;
        r_m_data     <= n_m_data;
        r_m_user     <= n_m_user;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_wr_ptr] <= w_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_rd_ptr];
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(RING_DEPTH))
        else $error("ring fill level above depth");

    a_ptr_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PTR_W'(r_wr_ptr - r_rd_ptr) == r_fill[PTR_W-1:0])
        else $error("ring pointers disagree with fill level");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("empty-ring read result is not all zero");

    a_read_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |=> (r_fill == $past(r_fill) - FILL_W'(1)))
        else $error("read did not pop the ring");
`endif

endmodule

`default_nettype wire
